>>> design/tmmd_pkg.sv
// ----------------------------------------------------------------------------
// Trace min/max decimator package
// Shared widths, register indexes, control types and saturation helpers.
// ----------------------------------------------------------------------------
package tmmd_pkg;

   // Field and state widths.
   localparam int SAMPLE_BITS   = 24;
   localparam int COUNT_BITS    = 17;
   localparam int PIXEL_BITS    = 13;
   localparam int GAIN_BITS     = 24;
   localparam int XSTEP_BITS    = 17;
   localparam int X_BITS        = 17;
   localparam int Y_BITS        = 18;
   localparam int ACC_BITS      = 29;
   localparam int INDEX_BITS    = 17;
   localparam int DIRECT_BITS   = 16;
   localparam int QUO_BITS      = 29;
   localparam int STEP_BITS     = 5;
   localparam int DIFF_BITS     = SAMPLE_BITS + 1;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int XPROD_BITS    = DIRECT_BITS + XSTEP_BITS;
   localparam int Y_SHIFT       = 8;
   localparam int X_FRAC_BITS   = 16;

   // Configuration port.
   localparam int ADDR_BITS     = 5;
   localparam int DATA_BITS     = 32;

   // Trace length limit and saturation points.
   localparam int MAX_SAMPLES   = 65536;
   localparam logic [COUNT_BITS-1:0] SAMPLE_LIMIT = COUNT_BITS'(MAX_SAMPLES);
   localparam logic [ACC_BITS-1:0]   ACC_MAX      = {ACC_BITS{1'b1}};
   localparam logic [PIXEL_BITS-1:0] COLUMN_LAST  = {PIXEL_BITS{1'b1}};
   localparam logic [QUO_BITS-1:0]   X_UNIT       = QUO_BITS'(1 << X_FRAC_BITS);
   localparam logic [X_BITS-1:0]     X_MAX        = {X_BITS{1'b1}};
   localparam logic [Y_BITS-1:0]     Y_MAX        = {1'b0, {(Y_BITS-1){1'b1}}};
   localparam logic [Y_BITS-1:0]     Y_MIN        = {1'b1, {(Y_BITS-1){1'b0}}};

   // Register indexes on the configuration port.
   typedef enum logic [2:0] {
      REG_SAMPLE_COUNT = 3'd0,
      REG_PIXEL_COUNT  = 3'd1,
      REG_BOTTOM_LEVEL = 3'd2,
      REG_TOP_LEVEL    = 3'd3,
      REG_Y_GAIN       = 3'd4,
      REG_X_STEP       = 3'd5
   } reg_index_type;

   // Column position calibration after a pixel count change.
   typedef enum logic [1:0] {
      CAL_IDLE,
      CAL_STEP,
      CAL_COLUMN
   } cal_state_type;

   // Status of the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Floor of product / 256, saturated to the signed result range.
   function automatic logic [Y_BITS-1:0] sat_y(input logic signed [PROD_BITS-1:0] product);
      logic signed [PROD_BITS-Y_SHIFT-1:0] scaled;
      logic signed [PROD_BITS-Y_SHIFT-1:0] hi_lim;
      logic signed [PROD_BITS-Y_SHIFT-1:0] lo_lim;
      scaled = product[PROD_BITS-1:Y_SHIFT];
      hi_lim = {{(PROD_BITS-Y_SHIFT-Y_BITS){1'b0}}, Y_MAX};
      lo_lim = {{(PROD_BITS-Y_SHIFT-Y_BITS){1'b1}}, Y_MIN};
      if (scaled > hi_lim) begin
         sat_y = Y_MAX;
      end else if (scaled < lo_lim) begin
         sat_y = Y_MIN;
      end else begin
         sat_y = scaled[Y_BITS-1:0];
      end
   endfunction

   // Unsigned position saturated to the result range.
   function automatic logic [X_BITS-1:0] sat_x(input logic [XPROD_BITS-1:0] value);
      if (value > {{(XPROD_BITS-X_BITS){1'b0}}, X_MAX}) begin
         sat_x = X_MAX;
      end else begin
         sat_x = value[X_BITS-1:0];
      end
   endfunction

endpackage

>>> design/tmmd_divider.sv
// ----------------------------------------------------------------------------
// Trace min/max decimator serial divider
// Restoring divider, one quotient bit per cycle, for the column positions.
// ----------------------------------------------------------------------------
module tmmd_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [tmmd_pkg::QUO_BITS-1:0]        dividend,
   input  logic [tmmd_pkg::PIXEL_BITS-1:0]      divisor,
   output tmmd_pkg::div_status_type             status,
   output logic [tmmd_pkg::QUO_BITS-1:0]        quotient,
   output logic [tmmd_pkg::PIXEL_BITS-1:0]      remainder
);

   logic [tmmd_pkg::QUO_BITS-1:0]   quo_ff, quo_in;
   logic [tmmd_pkg::PIXEL_BITS-1:0] rem_ff, rem_in;
   logic [tmmd_pkg::PIXEL_BITS-1:0] divisor_ff;
   logic [tmmd_pkg::STEP_BITS-1:0]  step_ff;
   logic                            busy_ff;
   logic                            done_ff;
   logic [tmmd_pkg::PIXEL_BITS:0]   trial;
   logic [tmmd_pkg::PIXEL_BITS:0]   diff;
   logic                            fits;
   logic                            last;

   // One trial subtraction per cycle, dividend bits shifted in from the top.
   always_comb begin
      trial  = {rem_ff, quo_ff[tmmd_pkg::QUO_BITS-1]};
      diff   = trial - {1'b0, divisor_ff};
      fits   = trial >= {1'b0, divisor_ff};
      rem_in = fits ? diff[tmmd_pkg::PIXEL_BITS-1:0] : trial[tmmd_pkg::PIXEL_BITS-1:0];
      quo_in = {quo_ff[tmmd_pkg::QUO_BITS-2:0], fits};
      last   = step_ff == tmmd_pkg::STEP_BITS'(tmmd_pkg::QUO_BITS - 1);
   end

   // Control: a start restarts the division even while one is running.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

endmodule

>>> design/trace_min_max_decimator_core.sv
// ----------------------------------------------------------------------------
// Trace min/max decimator core
// Maps a stream of min/max trace samples onto graticule columns.
// ----------------------------------------------------------------------------
// The block accepts one sample beat per clock while req_stall is low; each
// point passes the stage-1, stage-2 and result registers after the sample that
// causes it. The count, min/max and accumulator updates all close in the accept
// cycle; the two level multipliers and the position multiplier feed stage 2. A
// write to pixel_count starts a calibration of the column positions in a
// shared serial divider (two divisions of 29 steps each), during which
// req_stall stays high; configuration writes are taken throughout.
module trace_min_max_decimator_core (
   input  logic                                     clock,
   input  logic                                     reset,

   // Sample channel.
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  req_sample_low,
   input  logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  req_sample_high,
   input  logic                                     req_trace_start,

   // Point channel.
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [tmmd_pkg::X_BITS-1:0]              rsp_x_pos,
   output logic signed [tmmd_pkg::Y_BITS-1:0]       rsp_y_low,
   output logic signed [tmmd_pkg::Y_BITS-1:0]       rsp_y_high,
   output logic                                     rsp_reduced,

   // Configuration port.
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [tmmd_pkg::ADDR_BITS-1:0]           paddr,
   input  logic [tmmd_pkg::DATA_BITS-1:0]           pwdata,
   output logic [tmmd_pkg::DATA_BITS-1:0]           prdata,
   output logic                                     pready
);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [tmmd_pkg::COUNT_BITS-1:0]          sample_count_ff;
   logic [tmmd_pkg::PIXEL_BITS-1:0]          pixel_count_ff;
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  bottom_level_ff;
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  top_level_ff;
   logic [tmmd_pkg::GAIN_BITS-1:0]           y_gain_ff;
   logic [tmmd_pkg::XSTEP_BITS-1:0]          x_step_ff;
   tmmd_pkg::reg_index_type                  cfg_index;
   logic                                     cfg_write;
   logic                                     pixel_write;

   assign pready      = 1'b1;
   assign cfg_index   = tmmd_pkg::reg_index_type'(paddr[tmmd_pkg::ADDR_BITS-1:2]);
   assign cfg_write   = psel && penable && pwrite;
   assign pixel_write = cfg_write && (cfg_index == tmmd_pkg::REG_PIXEL_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= tmmd_pkg::COUNT_BITS'(1);
         pixel_count_ff  <= tmmd_pkg::PIXEL_BITS'(1);
         bottom_level_ff <= '0;
         top_level_ff    <= '0;
         y_gain_ff       <= '0;
         x_step_ff       <= '0;
      end else if (cfg_write) begin
         unique case (cfg_index)
            tmmd_pkg::REG_SAMPLE_COUNT: sample_count_ff <= pwdata[tmmd_pkg::COUNT_BITS-1:0];
            tmmd_pkg::REG_PIXEL_COUNT:  pixel_count_ff  <= pwdata[tmmd_pkg::PIXEL_BITS-1:0];
            tmmd_pkg::REG_BOTTOM_LEVEL: bottom_level_ff <= pwdata[tmmd_pkg::SAMPLE_BITS-1:0];
            tmmd_pkg::REG_TOP_LEVEL:    top_level_ff    <= pwdata[tmmd_pkg::SAMPLE_BITS-1:0];
            tmmd_pkg::REG_Y_GAIN:       y_gain_ff       <= pwdata[tmmd_pkg::GAIN_BITS-1:0];
            tmmd_pkg::REG_X_STEP:       x_step_ff       <= pwdata[tmmd_pkg::XSTEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Register readback; signed levels read back sign extended.
   always_comb begin
      unique case (cfg_index)
         tmmd_pkg::REG_SAMPLE_COUNT: prdata = tmmd_pkg::DATA_BITS'(sample_count_ff);
         tmmd_pkg::REG_PIXEL_COUNT:  prdata = tmmd_pkg::DATA_BITS'(pixel_count_ff);
         tmmd_pkg::REG_BOTTOM_LEVEL: prdata = tmmd_pkg::DATA_BITS'(bottom_level_ff);
         tmmd_pkg::REG_TOP_LEVEL:    prdata = tmmd_pkg::DATA_BITS'(top_level_ff);
         tmmd_pkg::REG_Y_GAIN:       prdata = tmmd_pkg::DATA_BITS'(y_gain_ff);
         tmmd_pkg::REG_X_STEP:       prdata = tmmd_pkg::DATA_BITS'(x_step_ff);
         default:                    prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Column position calibration
   // ------------------------------------------------------------------------
   // The column x position floor(column * 65536 / pixels) is kept as a
   // quotient and remainder that advance by 65536 / pixels per column. A
   // pixel count change first divides 65536 by it, then recomputes the
   // position of the current column.
   tmmd_pkg::cal_state_type               cal_state_ff, cal_state_in;
   tmmd_pkg::div_status_type              div_status;
   logic                                  div_start;
   logic [tmmd_pkg::QUO_BITS-1:0]         div_dividend;
   logic [tmmd_pkg::PIXEL_BITS-1:0]       div_divisor;
   logic [tmmd_pkg::QUO_BITS-1:0]         div_quotient;
   logic [tmmd_pkg::PIXEL_BITS-1:0]       div_remainder;
   logic                                  step_load;
   logic                                  column_load;
   logic                                  pixel_zero;

   assign pixel_zero = pixel_count_ff == '0;

   tmmd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_state_ff <= tmmd_pkg::CAL_IDLE;
      end else begin
         cal_state_ff <= cal_state_in;
      end
   end

   always_comb begin
      cal_state_in = cal_state_ff;
      div_start    = 1'b0;
      div_dividend = tmmd_pkg::X_UNIT;
      div_divisor  = pixel_count_ff;
      step_load    = 1'b0;
      column_load  = 1'b0;
      unique case (cal_state_ff)
         tmmd_pkg::CAL_IDLE: begin
         end
         tmmd_pkg::CAL_STEP: begin
            if (div_status.done) begin
               step_load    = 1'b1;
               div_start    = 1'b1;
               div_dividend = {column_index_ff, {tmmd_pkg::X_FRAC_BITS{1'b0}}};
               cal_state_in = tmmd_pkg::CAL_COLUMN;
            end
         end
         tmmd_pkg::CAL_COLUMN: begin
            if (div_status.done) begin
               column_load  = 1'b1;
               cal_state_in = tmmd_pkg::CAL_IDLE;
            end
         end
         default: cal_state_in = tmmd_pkg::CAL_IDLE;
      endcase
      // A new pixel count restarts the calibration.
      if (pixel_write) begin
         step_load    = 1'b0;
         column_load  = 1'b0;
         div_start    = 1'b1;
         div_dividend = tmmd_pkg::X_UNIT;
         div_divisor  = pwdata[tmmd_pkg::PIXEL_BITS-1:0];
         cal_state_in = tmmd_pkg::CAL_STEP;
      end
   end

   // ------------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------------
   logic rsp_valid_ff;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff;
   logic out_en;
   logic s2_en;
   logic s1_en;
   logic accept;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s2_en     = !s2_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = (cal_state_ff != tmmd_pkg::CAL_IDLE) || !s1_en;
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------------
   // Trace state and accept stage
   // ------------------------------------------------------------------------
   logic [tmmd_pkg::INDEX_BITS-1:0]          sample_index_ff, sample_index_in;
   logic [tmmd_pkg::PIXEL_BITS-1:0]          column_index_ff, column_index_in;
   logic [tmmd_pkg::ACC_BITS-1:0]            position_acc_ff, position_acc_in;
   logic [tmmd_pkg::ACC_BITS-1:0]            threshold_acc_ff, threshold_acc_in;
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  running_low_ff, running_low_in;
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  running_high_ff, running_high_in;
   logic [tmmd_pkg::QUO_BITS-1:0]            column_x_ff, column_x_in;
   logic [tmmd_pkg::PIXEL_BITS-1:0]          column_rem_ff, column_rem_in;
   logic [tmmd_pkg::XSTEP_BITS-1:0]          step_quo_ff, step_quo_in;
   logic [tmmd_pkg::PIXEL_BITS-1:0]          step_rem_ff, step_rem_in;

   // Values after an optional trace start.
   logic [tmmd_pkg::INDEX_BITS-1:0]          index_eff;
   logic [tmmd_pkg::PIXEL_BITS-1:0]          column_eff;
   logic [tmmd_pkg::ACC_BITS-1:0]            position_eff;
   logic [tmmd_pkg::ACC_BITS-1:0]            threshold_eff;
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  low_eff;
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  high_eff;
   logic [tmmd_pkg::QUO_BITS-1:0]            column_x_eff;
   logic [tmmd_pkg::PIXEL_BITS-1:0]          column_rem_eff;

   logic [tmmd_pkg::COUNT_BITS-1:0]          count_eff;
   logic [tmmd_pkg::COUNT_BITS-1:0]          span;
   logic                                     in_range;
   logic                                     direct;
   logic                                     fire;
   logic [tmmd_pkg::ACC_BITS:0]              position_sum;
   logic [tmmd_pkg::ACC_BITS-1:0]            position_next;
   logic [tmmd_pkg::ACC_BITS:0]              threshold_sum;
   logic [tmmd_pkg::ACC_BITS-1:0]            threshold_next;
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  low_min;
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  high_max;
   logic [tmmd_pkg::PIXEL_BITS:0]            rem_sum;
   logic                                     rem_carry;

   always_comb begin
      // Trace start clears the counters and re-arms the tracker.
      if (req_trace_start) begin
         index_eff      = '0;
         column_eff     = '0;
         position_eff   = '0;
         threshold_eff  = '0;
         low_eff        = top_level_ff;
         high_eff       = bottom_level_ff;
         column_x_eff   = '0;
         column_rem_eff = '0;
      end else begin
         index_eff      = sample_index_ff;
         column_eff     = column_index_ff;
         position_eff   = position_acc_ff;
         threshold_eff  = threshold_acc_ff;
         low_eff        = running_low_ff;
         high_eff       = running_high_ff;
         column_x_eff   = column_x_ff;
         column_rem_eff = column_rem_ff;
      end

      count_eff = (sample_count_ff > tmmd_pkg::SAMPLE_LIMIT) ? tmmd_pkg::SAMPLE_LIMIT
                                                             : sample_count_ff;
      span      = (sample_count_ff == '0) ? '0 : sample_count_ff - 1'b1;
      in_range  = index_eff < count_eff;
      direct    = sample_count_ff < tmmd_pkg::COUNT_BITS'(pixel_count_ff);

      // Saturating accumulators for the exact column step test.
      position_sum   = {1'b0, position_eff} + (tmmd_pkg::ACC_BITS + 1)'(pixel_count_ff);
      position_next  = position_sum[tmmd_pkg::ACC_BITS] ? tmmd_pkg::ACC_MAX
                                                        : position_sum[tmmd_pkg::ACC_BITS-1:0];
      threshold_sum  = {1'b0, threshold_eff} + (tmmd_pkg::ACC_BITS + 1)'(span);
      threshold_next = threshold_sum[tmmd_pkg::ACC_BITS] ? tmmd_pkg::ACC_MAX
                                                         : threshold_sum[tmmd_pkg::ACC_BITS-1:0];
      fire           = position_next > threshold_eff;

      // Running min and max including this sample.
      low_min  = (req_sample_low  < low_eff)  ? req_sample_low  : low_eff;
      high_max = (req_sample_high > high_eff) ? req_sample_high : high_eff;

      // Next column position: add the step quotient, carry the remainder.
      rem_sum   = {1'b0, column_rem_eff} + {1'b0, step_rem_ff};
      rem_carry = !pixel_zero && (rem_sum >= {1'b0, pixel_count_ff});

      // State update.
      sample_index_in  = sample_index_ff;
      column_index_in  = column_index_ff;
      position_acc_in  = position_acc_ff;
      threshold_acc_in = threshold_acc_ff;
      running_low_in   = running_low_ff;
      running_high_in  = running_high_ff;
      column_x_in      = column_x_ff;
      column_rem_in    = column_rem_ff;
      s1_valid_in      = 1'b0;
      if (accept) begin
         sample_index_in  = index_eff;
         column_index_in  = column_eff;
         position_acc_in  = position_eff;
         threshold_acc_in = threshold_eff;
         running_low_in   = low_eff;
         running_high_in  = high_eff;
         column_x_in      = column_x_eff;
         column_rem_in    = column_rem_eff;
         if (in_range) begin
            sample_index_in = index_eff + 1'b1;
            position_acc_in = position_next;
            if (direct) begin
               s1_valid_in = 1'b1;
            end else begin
               running_low_in  = low_min;
               running_high_in = high_max;
               if (fire) begin
                  s1_valid_in      = 1'b1;
                  threshold_acc_in = threshold_next;
                  column_index_in  = column_eff + 1'b1;
                  running_low_in   = top_level_ff;
                  running_high_in  = bottom_level_ff;
                  if (column_eff == tmmd_pkg::COLUMN_LAST) begin
                     column_x_in   = '0;
                     column_rem_in = '0;
                  end else begin
                     column_x_in   = column_x_eff + tmmd_pkg::QUO_BITS'(step_quo_ff)
                                   + tmmd_pkg::QUO_BITS'(rem_carry);
                     column_rem_in = rem_carry
                                   ? tmmd_pkg::PIXEL_BITS'(rem_sum - {1'b0, pixel_count_ff})
                                   : rem_sum[tmmd_pkg::PIXEL_BITS-1:0];
                  end
               end
            end
         end
      end

      // Calibration results replace the column step and the column position.
      step_quo_in = step_quo_ff;
      step_rem_in = step_rem_ff;
      if (step_load) begin
         step_quo_in = pixel_zero ? '0 : div_quotient[tmmd_pkg::XSTEP_BITS-1:0];
         step_rem_in = pixel_zero ? '0 : div_remainder;
      end
      if (column_load) begin
         column_x_in   = pixel_zero ? '0 : div_quotient;
         column_rem_in = pixel_zero ? '0 : div_remainder;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff  <= '0;
         column_index_ff  <= '0;
         position_acc_ff  <= '0;
         threshold_acc_ff <= '0;
         running_low_ff   <= '0;
         running_high_ff  <= '0;
         column_x_ff      <= '0;
         column_rem_ff    <= '0;
         step_quo_ff      <= tmmd_pkg::XSTEP_BITS'(tmmd_pkg::X_UNIT);
         step_rem_ff      <= '0;
      end else begin
         sample_index_ff  <= sample_index_in;
         column_index_ff  <= column_index_in;
         position_acc_ff  <= position_acc_in;
         threshold_acc_ff <= threshold_acc_in;
         running_low_ff   <= running_low_in;
         running_high_ff  <= running_high_in;
         column_x_ff      <= column_x_in;
         column_rem_ff    <= column_rem_in;
         step_quo_ff      <= step_quo_in;
         step_rem_ff      <= step_rem_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: levels and position source of the point
   // ------------------------------------------------------------------------
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  s1_low_ff;
   logic signed [tmmd_pkg::SAMPLE_BITS-1:0]  s1_high_ff;
   logic                                     s1_reduced_ff;
   logic [tmmd_pkg::DIRECT_BITS-1:0]         s1_index_ff;
   logic [tmmd_pkg::QUO_BITS-1:0]            s1_column_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en && s1_valid_in) begin
         s1_low_ff      <= direct ? req_sample_low  : low_min;
         s1_high_ff     <= direct ? req_sample_high : high_max;
         s1_reduced_ff  <= !direct;
         s1_index_ff    <= index_eff[tmmd_pkg::DIRECT_BITS-1:0];
         s1_column_x_ff <= column_x_eff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: level and position products
   // ------------------------------------------------------------------------
   logic signed [tmmd_pkg::DIFF_BITS-1:0]    gain_signed;
   logic signed [tmmd_pkg::DIFF_BITS-1:0]    diff_low;
   logic signed [tmmd_pkg::DIFF_BITS-1:0]    diff_high;
   logic [tmmd_pkg::XPROD_BITS-1:0]          x_product;
   logic signed [tmmd_pkg::PROD_BITS-1:0]    s2_prod_low_ff;
   logic signed [tmmd_pkg::PROD_BITS-1:0]    s2_prod_high_ff;
   logic [tmmd_pkg::XPROD_BITS-1:0]          s2_x_raw_ff;
   logic                                     s2_reduced_ff;

   always_comb begin
      gain_signed = {1'b0, y_gain_ff};
      diff_low    = {s1_low_ff[tmmd_pkg::SAMPLE_BITS-1], s1_low_ff}
                  - {bottom_level_ff[tmmd_pkg::SAMPLE_BITS-1], bottom_level_ff};
      diff_high   = {s1_high_ff[tmmd_pkg::SAMPLE_BITS-1], s1_high_ff}
                  - {bottom_level_ff[tmmd_pkg::SAMPLE_BITS-1], bottom_level_ff};
      x_product   = s1_reduced_ff ? tmmd_pkg::XPROD_BITS'(s1_column_x_ff)
                                  : tmmd_pkg::XPROD_BITS'(s1_index_ff) *
                                    tmmd_pkg::XPROD_BITS'(x_step_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         s2_prod_low_ff  <= gain_signed * diff_low;
         s2_prod_high_ff <= gain_signed * diff_high;
         s2_x_raw_ff     <= x_product;
         s2_reduced_ff   <= s1_reduced_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: scaling, saturation and the result register
   // ------------------------------------------------------------------------
   logic [tmmd_pkg::X_BITS-1:0]              rsp_x_pos_ff;
   logic [tmmd_pkg::Y_BITS-1:0]              rsp_y_low_ff;
   logic [tmmd_pkg::Y_BITS-1:0]              rsp_y_high_ff;
   logic                                     rsp_reduced_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s2_valid_ff) begin
         rsp_x_pos_ff   <= tmmd_pkg::sat_x(s2_x_raw_ff);
         rsp_y_low_ff   <= tmmd_pkg::sat_y(s2_prod_low_ff);
         rsp_y_high_ff  <= tmmd_pkg::sat_y(s2_prod_high_ff);
         rsp_reduced_ff <= s2_reduced_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_pos   = rsp_x_pos_ff;
   assign rsp_y_low   = rsp_y_low_ff;
   assign rsp_y_high  = rsp_y_high_ff;
   assign rsp_reduced = rsp_reduced_ff;

endmodule
